@@ sv/rvex_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_pkg
// Operation codes and the per-item record that travels down the execute pipe.
// ----------------------------------------------------------------------------
package rvex_pkg;

	localparam int unsigned XLEN = 32;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_AND = 5'd2, OP_OR = 5'd3, OP_XOR = 5'd4,
		OP_SLL = 5'd5, OP_SRL = 5'd6, OP_SRA = 5'd7, OP_SLT = 5'd8, OP_SLTU = 5'd9,
		OP_MUL = 5'd10, OP_MULH = 5'd11, OP_MULHU = 5'd12, OP_MULHSU = 5'd13,
		OP_DIV = 5'd14, OP_DIVU = 5'd15, OP_REM = 5'd16, OP_REMU = 5'd17,
		OP_LUI = 5'd18, OP_AUIPC = 5'd19
	} op_t;

	// Item state carried from cell to cell of the divider chain.
	typedef struct packed {
		logic        valid;
		logic [4:0]  dest;
		logic        is_div;   // divide or remainder item
		logic        want_rem;
		logic        neg_q;
		logic        neg_r;
		logic        zero;
		logic [31:0] a_raw;    // dividend as given, for divide-by-zero remainder
		logic [31:0] quo;      // shifts in quotient bits, dividend bits shift out
		logic [32:0] rem;      // partial remainder
		logic [31:0] dvs;      // divisor magnitude
		logic [31:0] res;      // result for non-divide items
		logic        bad;
	} cell_t;

endpackage
`default_nettype wire

@@ sv/rvex_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_cell
// One restoring-division cell: settles two quotient bits and registers the item.
// ----------------------------------------------------------------------------
module rvex_cell import rvex_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cell_t d,
	output cell_t      q
);
	cell_t  nx;
	logic [32:0] r1, r2, t1, t2;
	logic [31:0] qq;

	// Two shift-subtract steps on the partial remainder
	always_comb begin
		nx = d;
		qq = d.quo;
		r1 = {d.rem[31:0], qq[31]};
		qq = {qq[30:0], 1'b0};
		t1 = r1 - {1'b0, d.dvs};
		if (!t1[32]) begin
			r1 = t1;
			qq[0] = 1'b1;
		end
		r2 = {r1[31:0], qq[31]};
		qq = {qq[30:0], 1'b0};
		t2 = r2 - {1'b0, d.dvs};
		if (!t2[32]) begin
			r2 = t2;
			qq[0] = 1'b1;
		end
		if (d.is_div) begin
			nx.rem = r2;
			nx.quo = qq;
		end
	end

	// Advance the item to the next cell; reset clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q <= '0;
		else q <= nx;
	end
endmodule
`default_nettype wire

@@ sv/rvex_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_front
// Entry stage: combinational ALU ops, two-stage multiply, divide setup.
// ----------------------------------------------------------------------------
module rvex_front import rvex_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [4:0]  op,
	input  wire logic        use_imm,
	input  wire logic [31:0] src_a,
	input  wire logic [31:0] src_b,
	input  wire logic [31:0] imm_value,
	input  wire logic [31:0] pc_value,
	input  wire logic [4:0]  dest_in,
	output cell_t            q
);
	logic [31:0] opb, res, am, bm;
	logic [4:0]  sh;
	logic        bad, sa, sb, dv;
	cell_t       s1;
	logic        mul_s1, mhi_s1;
	logic [65:0] prod;

	// Operand selection and the combinational operations
	always_comb begin
		opb = use_imm ? imm_value : src_b;
		sh = opb[4:0];
		res = '0;
		bad = 1'b0;
		case (op)
			OP_ADD:   res = src_a + opb;
			OP_SUB:   res = src_a - src_b;
			OP_AND:   res = src_a & opb;
			OP_OR:    res = src_a | opb;
			OP_XOR:   res = src_a ^ opb;
			OP_SLL:   res = src_a << sh;
			OP_SRL:   res = src_a >> sh;
			OP_SRA:   res = 32'($signed(src_a) >>> sh);
			OP_SLT:   res = {31'd0, $signed(src_a) < $signed(opb)};
			OP_SLTU:  res = {31'd0, src_a < opb};
			OP_LUI:   if (use_imm) res = imm_value; else bad = 1'b1;
			OP_AUIPC: if (use_imm) res = pc_value + imm_value; else bad = 1'b1;
			OP_MUL, OP_MULH, OP_MULHU, OP_MULHSU,
			OP_DIV, OP_DIVU, OP_REM, OP_REMU: res = '0;
			default:  bad = 1'b1;
		endcase
		dv = (op == OP_DIV) || (op == OP_DIVU) || (op == OP_REM) || (op == OP_REMU);
		sa = ((op == OP_DIV) || (op == OP_REM)) && src_a[31];
		sb = ((op == OP_DIV) || (op == OP_REM)) && src_b[31];
		am = sa ? -src_a : src_a;
		bm = sb ? -src_b : src_b;
	end

	// Stage 1: register operands and multiplier inputs
	logic [32:0] ma_s1, mb_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else begin
			s1.valid <= start;
			s1.dest <= dest_in; s1.is_div <= dv;
			s1.want_rem <= (op == OP_REM) || (op == OP_REMU);
			s1.neg_q <= sa ^ sb; s1.neg_r <= sa; s1.zero <= (src_b == '0);
			s1.a_raw <= src_a; s1.quo <= am; s1.rem <= '0; s1.dvs <= bm;
			s1.res <= res; s1.bad <= bad;
		end
	end
	always_ff @(posedge clk) begin
		mul_s1 <= (op == OP_MUL) || (op == OP_MULH) || (op == OP_MULHU)
			|| (op == OP_MULHSU);
		mhi_s1 <= op != OP_MUL;
		ma_s1 <= {((op == OP_MULH) || (op == OP_MULHSU)) && src_a[31], src_a};
		mb_s1 <= {(op == OP_MULH) && src_b[31], src_b};
	end

	// Multiply in the second stage, result folded into the item
	always_comb begin
		prod = 66'($signed(ma_s1) * $signed(mb_s1));
		q = s1;
		if (mul_s1) q.res = mhi_s1 ? prod[63:32] : prod[31:0];
	end
endmodule
`default_nettype wire

@@ sv/rv32im_integer_execute_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rv32im_integer_execute_unit
// RV32IM integer execute: ALU, multiply and divide in one fixed-latency pipe.
// ----------------------------------------------------------------------------
// Usage: drive an item on op/use_imm/src_a/src_b/imm_value/pc_value/dest_in
// with start high; busy is always low, so one item is taken every cycle.
// Every item, whatever its operation, leaves in order on the outputs
// result_value/dest_out/unsupported with done high for one cycle.
// The path runs through the divider chain: one entry register, then sixteen
// cells that each settle two quotient bits, then the output register.
// Multiply is a 33x33 signed product between the entry register and the
// first cell. Throughput is one item per cycle.
// Reset clears all valid bits; no results appear until items are accepted.
// The receiver cannot stall: done must be taken when it is high.
// ----------------------------------------------------------------------------
module rv32im_integer_execute_unit import rvex_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  op,
	input  wire logic        use_imm,
	input  wire logic [31:0] src_a,
	input  wire logic [31:0] src_b,
	input  wire logic [31:0] imm_value,
	input  wire logic [31:0] pc_value,
	input  wire logic [4:0]  dest_in,
	output logic             done,
	output logic [31:0]      result_value,
	output logic [4:0]       dest_out,
	output logic             unsupported
);
	localparam int unsigned NCELL = XLEN / 2;

	cell_t chain [NCELL+1];
	logic [31:0] fin;

	assign busy = 1'b0;

	rvex_front u_front (
		.clk, .arst_n, .start, .op, .use_imm, .src_a, .src_b,
		.imm_value, .pc_value, .dest_in, .q(chain[0])
	);

	// Row of divider cells
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rvex_cell u_cell (.clk, .arst_n, .d(chain[i]), .q(chain[i+1]));
	end

	// Fix signs and special divide cases
	always_comb begin
		cell_t t;
		t = chain[NCELL];
		fin = t.res;
		if (t.is_div) begin
			if (t.want_rem) fin = t.zero ? t.a_raw : (t.neg_r ? -t.rem[31:0] : t.rem[31:0]);
			else fin = t.zero ? 32'hffff_ffff : (t.neg_q ? -t.quo : t.quo);
		end
		if (t.bad) fin = '0;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= chain[NCELL].valid;
	end
	always_ff @(posedge clk) begin
		result_value <= fin;
		dest_out <= chain[NCELL].dest;
		unsupported <= chain[NCELL].bad;
	end

	a_no_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy raised");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && unsupported |-> result_value == '0) else $error("bad item nonzero");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		chain[0].valid |-> ##(NCELL+1) done) else $error("item lost");
	a_in: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> chain[0].valid) else $error("item not taken");
endmodule
`default_nettype wire
